FILE: src/bcfp_pkg.sv
// bcfp_pkg: shared constants, types and tables for the bracketed command frame parser
// no dependencies; compiled first
`timescale 1ns / 1ps

package bcfp_pkg;

    // default configuration
    localparam int MAX_PAYLOAD_DEF = 49;
    localparam int FRAC_BITS_DEF   = 16;

    // fixed field widths
    localparam int GAIN_W       = 32;
    localparam int EV_W         = 4;
    localparam int FRAC_W       = 24;  // holds up to seven decimal fraction digits
    localparam int DIG_W        = 3;
    localparam logic [DIG_W-1:0] FRAC_DIG_MAX = 3'd7;

    // event codes
    localparam logic [EV_W-1:0] EV_NONE     = 4'd0;
    localparam logic [EV_W-1:0] EV_START    = 4'd1;
    localparam logic [EV_W-1:0] EV_GAINS    = 4'd2;
    localparam logic [EV_W-1:0] EV_MISSING  = 4'd3;
    localparam logic [EV_W-1:0] EV_LED_ON   = 4'd4;
    localparam logic [EV_W-1:0] EV_LED_OFF  = 4'd5;
    localparam logic [EV_W-1:0] EV_LED_BAD  = 4'd6;
    localparam logic [EV_W-1:0] EV_UNKNOWN  = 4'd7;
    localparam logic [EV_W-1:0] EV_OVERFLOW = 4'd8;

    // powers of ten by fraction digit count
    localparam logic [FRAC_W-1:0] DEC_SCALE [8] = '{
        24'd1, 24'd10, 24'd100, 24'd1000,
        24'd10000, 24'd100000, 24'd1000000, 24'd10000000
    };

    // bits needed to hold a fraction of that many digits (ceil log2 of the power)
    localparam int DEC_SHIFT [8] = '{0, 4, 7, 10, 14, 17, 20, 24};

    // number scanner phases
    typedef enum logic [2:0] {
        NP_LEAD,
        NP_SIGN,
        NP_INT,
        NP_FRAC,
        NP_DONE
    } num_phase_t;

    // per-byte actions for the commit stage
    typedef struct packed {
        logic            close;    // a numeric token ends with this byte
        logic [1:0]      slot;     // gain slot of that token
        logic            commit;   // copy pending gains to committed
        logic            clear;    // frame state is cleared after this byte
        logic            led_wr;
        logic            led_val;
        logic [EV_W-1:0] ev;
    } bcfp_ctrl_t;

endpackage

FILE: src/bcfp_if.sv
// bcfp_in_if / bcfp_out_if: valid/ready channels of the command frame parser
// no dependencies
`timescale 1ns / 1ps

interface bcfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface bcfp_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         event_res;
    logic signed [31:0] gain_p;
    logic signed [31:0] gain_i;
    logic signed [31:0] gain_d;
    logic               led_on;

    modport source (
        output valid, output event_res, output gain_p, output gain_i,
        output gain_d, output led_on, input ready
    );
    modport sink (
        input valid, input event_res, input gain_p, input gain_i,
        input gain_d, input led_on, output ready
    );
endinterface

FILE: src/bcfp_parser.sv
// bcfp_parser: per-byte frame, token, keyword and decimal scanner state
// depends on bcfp_pkg
`timescale 1ns / 1ps

module bcfp_parser #(
    parameter int MAX_PAYLOAD = bcfp_pkg::MAX_PAYLOAD_DEF,
    parameter int FRAC_BITS   = bcfp_pkg::FRAC_BITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     take,
    input  logic [7:0]                               rx_byte,
    output bcfp_pkg::bcfp_ctrl_t                     ctrl,
    output logic                                     num_neg,
    output logic                                     num_big,
    output logic [bcfp_pkg::GAIN_W-FRAC_BITS-1:0]    num_int,
    output logic [bcfp_pkg::FRAC_W-1:0]              num_frac,
    output logic [bcfp_pkg::DIG_W-1:0]               num_ndig
);
    import bcfp_pkg::*;

    localparam int IW = GAIN_W - FRAC_BITS;
    localparam int CW = $clog2(MAX_PAYLOAD + 1);

    // characters
    localparam logic [7:0] CH_OPEN  = 8'h5B;  // [
    localparam logic [7:0] CH_CLOSE = 8'h5D;  // ]
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_F     = 8'h46;

    // keyword matcher codes
    localparam logic [2:0] KW_IDLE = 3'd0;
    localparam logic [2:0] KW_P    = 3'd1;
    localparam logic [2:0] KW_PI   = 3'd2;
    localparam logic [2:0] KW_PID  = 3'd3;
    localparam logic [2:0] KW_L    = 3'd4;
    localparam logic [2:0] KW_LE   = 3'd5;
    localparam logic [2:0] KW_LED  = 3'd6;
    localparam logic [2:0] KW_FAIL = 3'd7;

    // argument matcher codes
    localparam logic [2:0] AM_IDLE = 3'd0;
    localparam logic [2:0] AM_O    = 3'd1;
    localparam logic [2:0] AM_ON   = 3'd2;
    localparam logic [2:0] AM_OF   = 3'd3;
    localparam logic [2:0] AM_OFF  = 3'd4;
    localparam logic [2:0] AM_FAIL = 3'd7;

    localparam logic [2:0] TOK_KEY  = 3'd1;
    localparam logic [2:0] TOK_ARG  = 3'd2;
    localparam logic [2:0] TOK_LAST = 3'd4;
    localparam logic [2:0] TOK_SAT  = 3'd5;

    function automatic logic [2:0] kw_step(input logic [2:0] s, input logic [7:0] c);
        logic [2:0] n;
        n = KW_FAIL;
        if (s == KW_IDLE && c == CH_P) n = KW_P;
        else if (s == KW_P && c == CH_I) n = KW_PI;
        else if (s == KW_PI && c == CH_D) n = KW_PID;
        else if (s == KW_IDLE && c == CH_L) n = KW_L;
        else if (s == KW_L && c == CH_E) n = KW_LE;
        else if (s == KW_LE && c == CH_D) n = KW_LED;
        return n;
    endfunction

    function automatic logic [2:0] arg_step(input logic [2:0] s, input logic [7:0] c);
        logic [2:0] n;
        n = AM_FAIL;
        if (s == AM_IDLE && c == CH_O) n = AM_O;
        else if (s == AM_O && c == CH_N) n = AM_ON;
        else if (s == AM_O && c == CH_F) n = AM_OF;
        else if (s == AM_OF && c == CH_F) n = AM_OFF;
        return n;
    endfunction

    logic             in_frame_reg, in_frame_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [2:0]       tok_reg, tok_next;
    logic [2:0]       kw_reg, kw_next;
    logic [2:0]       arg_reg, arg_next;
    logic             in_token_reg, in_token_next;
    logic             text_end_reg, text_end_next;
    num_phase_t       phase_reg, phase_next;
    logic [DIG_W-1:0] ndig_reg, ndig_next;
    logic             neg_reg, neg_next;
    logic             big_reg, big_next;
    logic [IW-1:0]    int_reg, int_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;

    logic room;
    logic close_hit;

    assign room      = (count_reg < CW'(MAX_PAYLOAD));
    assign close_hit = in_token_reg && (tok_reg >= TOK_ARG) && (tok_reg <= TOK_LAST);

    // next-state logic
    always_comb
    begin
        logic [2:0]        tok_eff;
        num_phase_t        phase_eff;
        logic [DIG_W-1:0]  ndig_eff;
        logic              neg_eff;
        logic              big_eff;
        logic [IW-1:0]     int_eff;
        logic [FRAC_W-1:0] frac_eff;
        logic              is_digit;
        logic              is_space;
        logic              mant;
        logic [3:0]        dval;
        logic [IW+3:0]     int_wide;
        logic [FRAC_W+3:0] frac_wide;

        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        tok_next      = tok_reg;
        kw_next       = kw_reg;
        arg_next      = arg_reg;
        in_token_next = in_token_reg;
        text_end_next = text_end_reg;
        phase_next    = phase_reg;
        ndig_next     = ndig_reg;
        neg_next      = neg_reg;
        big_next      = big_reg;
        int_next      = int_reg;
        frac_next     = frac_reg;

        is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
        is_space  = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
        dval      = rx_byte[3:0];
        tok_eff   = tok_reg;
        phase_eff = phase_reg;
        ndig_eff  = ndig_reg;
        neg_eff   = neg_reg;
        big_eff   = big_reg;
        int_eff   = int_reg;
        frac_eff  = frac_reg;
        mant      = 1'b0;
        int_wide  = '0;
        frac_wide = '0;

        if (take)
        begin
            if (!in_frame_reg || rx_byte == CH_CLOSE || !room)
            begin
                // frame opens, closes or overflows: clear the frame state
                if (!in_frame_reg)
                begin
                    in_frame_next = (rx_byte == CH_OPEN);
                end
                else
                begin
                    in_frame_next = 1'b0;
                end
                if (in_frame_reg || rx_byte == CH_OPEN)
                begin
                    count_next    = '0;
                    tok_next      = '0;
                    kw_next       = KW_IDLE;
                    arg_next      = AM_IDLE;
                    in_token_next = 1'b0;
                    text_end_next = 1'b0;
                    phase_next    = NP_LEAD;
                    ndig_next     = '0;
                    neg_next      = 1'b0;
                    big_next      = 1'b0;
                    int_next      = '0;
                    frac_next     = '0;
                end
            end
            else
            begin
                count_next = count_reg + CW'(1);
                if (!text_end_reg)
                begin
                    if (rx_byte == CH_NUL)
                    begin
                        in_token_next = 1'b0;
                        text_end_next = 1'b1;
                    end
                    else if (rx_byte == CH_COMMA)
                    begin
                        in_token_next = 1'b0;
                    end
                    else
                    begin
                        // first byte of a token restarts the number scanner
                        if (!in_token_reg)
                        begin
                            in_token_next = 1'b1;
                            if (tok_reg < TOK_SAT)
                            begin
                                tok_eff = tok_reg + 3'd1;
                            end
                            phase_eff = NP_LEAD;
                            ndig_eff  = '0;
                            neg_eff   = 1'b0;
                            big_eff   = 1'b0;
                            int_eff   = '0;
                            frac_eff  = '0;
                        end
                        tok_next   = tok_eff;
                        phase_next = phase_eff;
                        ndig_next  = ndig_eff;
                        neg_next   = neg_eff;
                        big_next   = big_eff;
                        int_next   = int_eff;
                        frac_next  = frac_eff;

                        if (tok_eff == TOK_KEY)
                        begin
                            kw_next = kw_step(kw_reg, rx_byte);
                        end
                        else if (tok_eff >= TOK_ARG && tok_eff <= TOK_LAST)
                        begin
                            if (tok_eff == TOK_ARG)
                            begin
                                arg_next = arg_step(arg_reg, rx_byte);
                            end

                            // decimal scanner
                            mant = (phase_eff == NP_SIGN) || (phase_eff == NP_INT);
                            if (phase_eff == NP_LEAD && !is_space)
                            begin
                                if (rx_byte == CH_PLUS || rx_byte == CH_MINUS)
                                begin
                                    neg_next   = (rx_byte == CH_MINUS);
                                    phase_next = NP_SIGN;
                                end
                                else
                                begin
                                    mant = 1'b1;
                                end
                            end

                            if (mant)
                            begin
                                if (is_digit)
                                begin
                                    int_wide   = (IW+4)'(int_eff) * (IW+4)'(10)
                                               + (IW+4)'(dval);
                                    big_next   = big_eff || (int_wide[IW+3:IW] != 4'd0);
                                    int_next   = int_wide[IW-1:0];
                                    phase_next = NP_INT;
                                end
                                else if (rx_byte == CH_DOT)
                                begin
                                    phase_next = NP_FRAC;
                                end
                                else
                                begin
                                    phase_next = NP_DONE;
                                end
                            end
                            else if (phase_eff == NP_FRAC)
                            begin
                                if (is_digit)
                                begin
                                    if (ndig_eff < FRAC_DIG_MAX)
                                    begin
                                        frac_wide = (FRAC_W+4)'(frac_eff) * (FRAC_W+4)'(10)
                                                  + (FRAC_W+4)'(dval);
                                        frac_next = frac_wide[FRAC_W-1:0];
                                        ndig_next = ndig_eff + DIG_W'(1);
                                    end
                                end
                                else
                                begin
                                    phase_next = NP_DONE;
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    // per-byte actions and event
    always_comb
    begin
        ctrl         = '0;
        ctrl.slot    = 2'(tok_reg - TOK_ARG);
        ctrl.ev      = EV_NONE;
        if (!in_frame_reg)
        begin
            if (rx_byte == CH_OPEN)
            begin
                ctrl.clear = 1'b1;
                ctrl.ev    = EV_START;
            end
        end
        else if (rx_byte == CH_CLOSE)
        begin
            ctrl.close = close_hit;
            ctrl.clear = 1'b1;
            if (tok_reg >= TOK_KEY && kw_reg == KW_PID)
            begin
                if (tok_reg >= TOK_LAST)
                begin
                    ctrl.commit = 1'b1;
                    ctrl.ev     = EV_GAINS;
                end
                else
                begin
                    ctrl.ev = EV_MISSING;
                end
            end
            else if (tok_reg >= TOK_KEY && kw_reg == KW_LED)
            begin
                if (tok_reg >= TOK_ARG && arg_reg == AM_ON)
                begin
                    ctrl.led_wr  = 1'b1;
                    ctrl.led_val = 1'b1;
                    ctrl.ev      = EV_LED_ON;
                end
                else if (tok_reg >= TOK_ARG && arg_reg == AM_OFF)
                begin
                    ctrl.led_wr  = 1'b1;
                    ctrl.led_val = 1'b0;
                    ctrl.ev      = EV_LED_OFF;
                end
                else
                begin
                    ctrl.ev = EV_LED_BAD;
                end
            end
            else
            begin
                ctrl.ev = EV_UNKNOWN;
            end
        end
        else if (room)
        begin
            if (!text_end_reg && (rx_byte == CH_NUL || rx_byte == CH_COMMA))
            begin
                ctrl.close = close_hit;
            end
        end
        else
        begin
            ctrl.clear = 1'b1;
            ctrl.ev    = EV_OVERFLOW;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
            tok_reg      <= '0;
            kw_reg       <= KW_IDLE;
            arg_reg      <= AM_IDLE;
            in_token_reg <= 1'b0;
            text_end_reg <= 1'b0;
            phase_reg    <= NP_LEAD;
            ndig_reg     <= '0;
            neg_reg      <= 1'b0;
            big_reg      <= 1'b0;
            int_reg      <= '0;
            frac_reg     <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
            tok_reg      <= tok_next;
            kw_reg       <= kw_next;
            arg_reg      <= arg_next;
            in_token_reg <= in_token_next;
            text_end_reg <= text_end_next;
            phase_reg    <= phase_next;
            ndig_reg     <= ndig_next;
            neg_reg      <= neg_next;
            big_reg      <= big_next;
            int_reg      <= int_next;
            frac_reg     <= frac_next;
        end
    end

    assign num_neg  = neg_reg;
    assign num_big  = big_reg;
    assign num_int  = int_reg;
    assign num_frac = frac_reg;
    assign num_ndig = ndig_reg;

endmodule

FILE: src/bcfp_conv.sv
// bcfp_conv: two-stage decimal to signed fixed-point conversion
// fraction = floor(frac * 2^FRAC_BITS / 10^ndig) by reciprocal multiply and one correction
// depends on bcfp_pkg
`timescale 1ns / 1ps

module bcfp_conv #(
    parameter int FRAC_BITS = bcfp_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  en1,
    input  logic                                  en2,
    input  logic                                  num_neg,
    input  logic                                  num_big,
    input  logic [bcfp_pkg::GAIN_W-FRAC_BITS-1:0] num_int,
    input  logic [bcfp_pkg::FRAC_W-1:0]           num_frac,
    input  logic [bcfp_pkg::DIG_W-1:0]            num_ndig,
    output logic [bcfp_pkg::GAIN_W-1:0]           value
);
    import bcfp_pkg::*;

    localparam int IW = GAIN_W - FRAC_BITS;
    localparam int RW = FRAC_BITS + 1;
    localparam int PW = RW + FRAC_W;
    localparam int QW = FRAC_BITS + FRAC_W;

    // truncated reciprocals 2^(FRAC_BITS+shift) / 10^n
    localparam logic [RW-1:0] RECIP [8] = '{
        RW'((64'd1 << (FRAC_BITS + DEC_SHIFT[0])) / 64'(DEC_SCALE[0])),
        RW'((64'd1 << (FRAC_BITS + DEC_SHIFT[1])) / 64'(DEC_SCALE[1])),
        RW'((64'd1 << (FRAC_BITS + DEC_SHIFT[2])) / 64'(DEC_SCALE[2])),
        RW'((64'd1 << (FRAC_BITS + DEC_SHIFT[3])) / 64'(DEC_SCALE[3])),
        RW'((64'd1 << (FRAC_BITS + DEC_SHIFT[4])) / 64'(DEC_SCALE[4])),
        RW'((64'd1 << (FRAC_BITS + DEC_SHIFT[5])) / 64'(DEC_SCALE[5])),
        RW'((64'd1 << (FRAC_BITS + DEC_SHIFT[6])) / 64'(DEC_SCALE[6])),
        RW'((64'd1 << (FRAC_BITS + DEC_SHIFT[7])) / 64'(DEC_SCALE[7]))
    };

    localparam logic [GAIN_W:0] MAG_SAT     = (GAIN_W+1)'(1) << GAIN_W;
    localparam logic [GAIN_W:0] MAG_NEG_LIM = (GAIN_W+1)'(1) << (GAIN_W - 1);
    localparam logic [GAIN_W:0] MAG_POS_LIM = MAG_NEG_LIM - (GAIN_W+1)'(1);

    logic              s1_neg_reg, s1_big_reg;
    logic [IW-1:0]     s1_int_reg;
    logic [FRAC_W-1:0] s1_frac_reg;
    logic [DIG_W-1:0]  s1_ndig_reg;
    logic [PW-1:0]     s1_prod_reg, s1_prod_next;

    logic                 s2_neg_reg, s2_big_reg;
    logic [IW-1:0]        s2_int_reg;
    logic [FRAC_W-1:0]    s2_frac_reg;
    logic [DIG_W-1:0]     s2_ndig_reg;
    logic [FRAC_BITS-1:0] s2_qest_reg, s2_qest_next;
    logic [QW-1:0]        s2_prod_reg, s2_prod_next;

    // stage 1: fraction times reciprocal
    assign s1_prod_next = PW'(num_frac) * PW'(RECIP[num_ndig]);

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_neg_reg  <= num_neg;
            s1_big_reg  <= num_big;
            s1_int_reg  <= num_int;
            s1_frac_reg <= num_frac;
            s1_ndig_reg <= num_ndig;
            s1_prod_reg <= s1_prod_next;
        end
    end

    // stage 2: quotient estimate and its back product
    assign s2_qest_next = FRAC_BITS'(s1_prod_reg >> DEC_SHIFT[s1_ndig_reg]);
    assign s2_prod_next = QW'(s2_qest_next) * QW'(DEC_SCALE[s1_ndig_reg]);

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_neg_reg  <= s1_neg_reg;
            s2_big_reg  <= s1_big_reg;
            s2_int_reg  <= s1_int_reg;
            s2_frac_reg <= s1_frac_reg;
            s2_ndig_reg <= s1_ndig_reg;
            s2_qest_reg <= s2_qest_next;
            s2_prod_reg <= s2_prod_next;
        end
    end

    // estimate is low by at most one; then assemble and saturate
    always_comb
    begin
        logic [QW:0]          numer;
        logic [QW:0]          bound;
        logic [FRAC_BITS-1:0] q;
        logic [GAIN_W:0]      mag;
        logic [GAIN_W:0]      mag_c;

        numer = (QW+1)'({s2_frac_reg, {FRAC_BITS{1'b0}}});
        bound = (QW+1)'(s2_prod_reg) + (QW+1)'(DEC_SCALE[s2_ndig_reg]);
        q     = s2_qest_reg + FRAC_BITS'(numer >= bound);

        if (s2_big_reg)
        begin
            mag = MAG_SAT;
        end
        else
        begin
            mag = {1'b0, s2_int_reg, q};
        end

        if (s2_neg_reg)
        begin
            mag_c = (mag > MAG_NEG_LIM) ? MAG_NEG_LIM : mag;
            value = GAIN_W'(0) - mag_c[GAIN_W-1:0];
        end
        else
        begin
            mag_c = (mag > MAG_POS_LIM) ? MAG_POS_LIM : mag;
            value = mag_c[GAIN_W-1:0];
        end
    end

endmodule

FILE: src/bracketed_command_frame_parser.sv
// Bracketed command frame parser: top level with handshake pipeline and commit stage
// Usage
//   rx (sink): one received ASCII byte per transfer. A frame opens on '[' and
//   closes on ']'; commas split the payload into tokens, empty ones skipped.
//   "PID,a,b,c" loads three signed fixed-point gains, "LED,ON"/"LED,OFF" set the LED.
//   report (source): exactly one result per accepted byte, in order: an event code
//   and the committed gains and LED state as they stand after that byte.
// Throughput and stages
//   one byte per cycle while report.ready stays high; taking a byte loads the parser
//   state and reciprocal product, stage 2 then registers the quotient estimate and
//   its back product, and the output register loads the assembled and committed result.
// Reset
//   rst_n clears the frame state, pending and committed gains and the LED;
//   no result is pending after reset.
// Stall
//   each stage holds while the one after it is full; the input keeps taking
//   bytes until all three stages hold results, so a stalled receiver backs up
//   to rx.ready after three bytes.
// Depends on bcfp_pkg, bcfp_if, bcfp_parser, bcfp_conv
`timescale 1ns / 1ps

module bracketed_command_frame_parser #(
    parameter int MAX_PAYLOAD = bcfp_pkg::MAX_PAYLOAD_DEF,
    parameter int FRAC_BITS   = bcfp_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    bcfp_in_if.sink           rx,
    bcfp_out_if.source        report
);
    import bcfp_pkg::*;

    localparam int IW = GAIN_W - FRAC_BITS;

    // pipeline occupancy
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_free, s2_free, s1_free;
    logic load_s1, load_s2, load_out;

    bcfp_ctrl_t        ctrl;
    bcfp_ctrl_t        s1_ctrl_reg, s2_ctrl_reg;
    logic              num_neg, num_big;
    logic [IW-1:0]     num_int;
    logic [FRAC_W-1:0] num_frac;
    logic [DIG_W-1:0]  num_ndig;
    logic [GAIN_W-1:0] value;

    // commit stage state
    logic [EV_W-1:0]   ev_reg;
    logic [GAIN_W-1:0] pend_reg [3];
    logic [GAIN_W-1:0] pend_next [3];
    logic [GAIN_W-1:0] gain_reg [3];
    logic [GAIN_W-1:0] gain_next [3];
    logic              led_reg, led_next;

    // handshake and stage advance
    assign out_free = !out_valid_reg || report.ready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign rx.ready = s1_free;
    assign load_s1  = rx.valid && s1_free;
    assign load_s2  = s1_valid_reg && s2_free;
    assign load_out = s2_valid_reg && out_free;

    assign s1_valid_next  = load_s1 || (s1_valid_reg && !s2_free);
    assign s2_valid_next  = load_s2 || (s2_valid_reg && !out_free);
    assign out_valid_next = load_out || (out_valid_reg && !report.ready);

    bcfp_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .FRAC_BITS   (FRAC_BITS)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (load_s1),
        .rx_byte  (rx.rx_byte),
        .ctrl     (ctrl),
        .num_neg  (num_neg),
        .num_big  (num_big),
        .num_int  (num_int),
        .num_frac (num_frac),
        .num_ndig (num_ndig)
    );

    bcfp_conv #(
        .FRAC_BITS (FRAC_BITS)
    ) u_conv (
        .clk      (clk),
        .en1      (load_s1),
        .en2      (load_s2),
        .num_neg  (num_neg),
        .num_big  (num_big),
        .num_int  (num_int),
        .num_frac (num_frac),
        .num_ndig (num_ndig),
        .value    (value)
    );

    // control fields follow the number through the conversion stages
    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            s1_ctrl_reg <= ctrl;
        end
        if (load_s2)
        begin
            s2_ctrl_reg <= s1_ctrl_reg;
        end
    end

    // pending write, commit and frame clear, in byte order
    always_comb
    begin
        logic [GAIN_W-1:0] pend_w [3];

        led_next = led_reg;
        for (int i = 0; i < 3; i++)
        begin
            pend_w[i] = pend_reg[i];
            if (s2_ctrl_reg.close && s2_ctrl_reg.slot == 2'(i))
            begin
                pend_w[i] = value;
            end
            gain_next[i] = s2_ctrl_reg.commit ? pend_w[i] : gain_reg[i];
            pend_next[i] = s2_ctrl_reg.clear ? '0 : pend_w[i];
        end
        if (s2_ctrl_reg.led_wr)
        begin
            led_next = s2_ctrl_reg.led_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ev_reg        <= EV_NONE;
            led_reg       <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                pend_reg[i] <= '0;
                gain_reg[i] <= '0;
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            if (load_out)
            begin
                ev_reg  <= s2_ctrl_reg.ev;
                led_reg <= led_next;
                for (int i = 0; i < 3; i++)
                begin
                    pend_reg[i] <= pend_next[i];
                    gain_reg[i] <= gain_next[i];
                end
            end
        end
    end

    // result channel
    assign report.valid     = out_valid_reg;
    assign report.event_res = ev_reg;
    assign report.gain_p    = $signed(gain_reg[0]);
    assign report.gain_i    = $signed(gain_reg[1]);
    assign report.gain_d    = $signed(gain_reg[2]);
    assign report.led_on    = led_reg;

endmodule
